[rtl/ctfm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctfm_pkg: shared types and constants of the trailing-field masker
// Command format between front and back, configuration bundle, register
// indexes and reset values.
// ----------------------------------------------------------------------------
package ctfm_pkg;

    localparam logic [7:0] COMMA_BYTE = 8'h2C;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_KEEP_FIELDS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MASK_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MASK_TEXT   = 2'd2;

    // configuration reset values
    localparam logic [3:0]  RST_KEEP_FIELDS = 4'd1;
    localparam logic [3:0]  RST_MASK_LENGTH = 4'd3;
    localparam logic [63:0] RST_MASK_TEXT   = 64'h0000_0000_002A_2A2A;

    typedef struct packed {
        logic [3:0]  keep_fields;
        logic [3:0]  mask_length;
        logic [63:0] mask_text;
    } t_cfg;

    // one classified item: what the back end must emit for it
    typedef struct packed {
        logic [7:0] data;    // byte to pass, or the comma after a mask
        logic       pass;    // emit data unchanged
        logic       mask1;   // emit mask, then the comma in data
        logic       mask2;   // emit a closing mask at payload end
        logic       done;    // last item of the payload
        logic       masked;  // payload reached the keep count
    } t_cmd;

endpackage

[rtl/ctfm_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctfm_front: input classifier
// Tracks comma count and masked-region flag per payload and turns each
// accepted item into a command for the back end. Items that produce no
// output are consumed without a command.
// ----------------------------------------------------------------------------
module ctfm_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ctfm_pkg::t_cfg    i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_data,
    input  logic              i_last,
    input  logic              i_q_ready,
    output logic              o_push,
    output ctfm_pkg::t_cmd    o_cmd
);
    import ctfm_pkg::*;

    logic [3:0] r_commas, n_commas;
    logic       r_region, n_region;
    logic       accept;
    logic       is_comma;
    logic       region_in;
    t_cmd       cmd;

    assign o_ready  = i_q_ready;
    assign accept   = i_valid && i_q_ready;
    assign is_comma = (i_data == COMMA_BYTE);
    assign region_in = r_region || (r_commas >= i_cfg.keep_fields);

    // classify the item and work out the next payload state
    always_comb begin
        cmd      = '0;
        cmd.data = i_data;
        n_commas = r_commas;
        n_region = region_in;
        if (!region_in) begin
            cmd.pass = 1'b1;
            if (is_comma && (r_commas < i_cfg.keep_fields)) begin
                n_commas = r_commas + 4'd1;
            end
            n_region = (n_commas >= i_cfg.keep_fields);
        end else begin
            cmd.mask1 = is_comma;
        end
        if (i_last) begin
            cmd.mask2  = n_region;
            cmd.done   = 1'b1;
            cmd.masked = n_region;
            n_commas   = '0;
            n_region   = 1'b0;
        end
    end

    assign o_cmd  = cmd;
    assign o_push = accept && (cmd.pass || cmd.mask1 || cmd.mask2);

    // payload state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_commas <= '0;
            r_region <= 1'b0;
        end else if (accept) begin
            r_commas <= n_commas;
            r_region <= n_region;
        end
    end

endmodule

[rtl/ctfm_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctfm_queue: two-entry command queue
// Decouples the classifier from the output sequencer so that either side
// can stall while the other keeps going.
// ----------------------------------------------------------------------------
module ctfm_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ctfm_pkg::t_cmd    i_cmd,
    output logic              o_ready,
    input  logic              i_pop,
    output logic              o_valid,
    output ctfm_pkg::t_cmd    o_cmd
);
    import ctfm_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (i_pop)  r_rd_ptr <= ~r_rd_ptr;
            if (i_push && !i_pop)      r_count <= r_count + 2'd1;
            else if (!i_push && i_pop) r_count <= r_count - 2'd1;
        end
    end

endmodule

[rtl/ctfm_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctfm_back: output sequencer
// Expands the command at the queue head into output items: passthrough
// byte, mask bytes with the separating comma, and the closing mask.
// Results go out through a registered output stage.
// ----------------------------------------------------------------------------
module ctfm_back #(
    parameter int unsigned MAX_MASK_BYTES = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ctfm_pkg::t_cfg    i_cfg,
    input  logic              i_q_valid,
    input  ctfm_pkg::t_cmd    i_q_cmd,
    output logic              o_q_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_byte,
    output logic              o_run_last,
    output logic              o_done,
    output logic              o_masked
);
    import ctfm_pkg::*;

    localparam int unsigned CW = (MAX_MASK_BYTES > 1) ? $clog2(MAX_MASK_BYTES) : 1;

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_MASK1,
        PH_BYTE,
        PH_MASK2
    } t_phase;

    t_phase          r_phase, n_phase, eff_phase;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [3:0]      mask_n;
    logic            last_mask;
    logic            emit;
    logic            cmd_end;
    logic [7:0]      sel_byte;
    logic [7:0]      mask_byte;

    logic            r_out_valid;
    logic [7:0]      r_out_byte;
    logic            r_run_last, r_done, r_masked;

    // effective mask length, clamped to 1..MAX_MASK_BYTES
    always_comb begin
        if (i_cfg.mask_length == 4'd0) begin
            mask_n = 4'd1;
        end else if (i_cfg.mask_length > 4'(MAX_MASK_BYTES)) begin
            mask_n = 4'(MAX_MASK_BYTES);
        end else begin
            mask_n = i_cfg.mask_length;
        end
    end

    assign last_mask = (4'(r_cnt) == (mask_n - 4'd1));
    assign mask_byte = i_cfg.mask_text[{r_cnt, 3'b000} +: 8];
    assign emit      = i_q_valid && (!r_out_valid || i_ready);

    // phase of the head command; a fresh command picks its first step
    always_comb begin
        if (r_phase == PH_FIRST) begin
            priority if (i_q_cmd.mask1) eff_phase = PH_MASK1;
            else if (i_q_cmd.pass)      eff_phase = PH_BYTE;
            else                        eff_phase = PH_MASK2;
        end else begin
            eff_phase = r_phase;
        end
    end

    // step sequencing
    always_comb begin
        n_phase  = eff_phase;
        n_cnt    = r_cnt;
        cmd_end  = 1'b0;
        sel_byte = i_q_cmd.data;
        unique case (eff_phase)
            PH_MASK1: begin
                sel_byte = mask_byte;
                if (last_mask) begin
                    n_phase = PH_BYTE;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            PH_BYTE: begin
                if (i_q_cmd.mask2) begin
                    n_phase = PH_MASK2;
                    n_cnt   = '0;
                end else begin
                    cmd_end = 1'b1;
                end
            end
            PH_MASK2: begin
                sel_byte = mask_byte;
                if (last_mask) begin
                    cmd_end = 1'b1;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            default: begin
                cmd_end = 1'b1;
            end
        endcase
        if (cmd_end) begin
            n_phase = PH_FIRST;
            n_cnt   = '0;
        end
    end

    assign o_q_pop = emit && cmd_end;

    // sequencer state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_FIRST;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_phase    <= n_phase;
                r_cnt      <= n_cnt;
                r_out_byte <= sel_byte;
                r_run_last <= cmd_end;
                r_done     <= cmd_end && i_q_cmd.done;
                r_masked   <= cmd_end && i_q_cmd.done && i_q_cmd.masked;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid    = r_out_valid;
    assign o_byte     = r_out_byte;
    assign o_run_last = r_run_last;
    assign o_done     = r_done;
    assign o_masked   = r_masked;

    // checks
    a_masked_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_masked) |-> r_done)
        else $error("was_masked without payload_done");

    a_done_on_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_done) |-> r_run_last)
        else $error("payload_done without run_last");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        4'(r_cnt) < mask_n)
        else $error("mask byte counter past mask length");

    a_fresh_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_q_valid) |-> (r_phase == PH_FIRST))
        else $error("sequencer mid-command with empty queue");

endmodule

[rtl/csv_trailing_field_masker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_trailing_field_masker: trailing CSV field redaction
// Passes leading comma-separated fields and replaces each later field with
// a configurable mask string, keeping the commas between fields.
//
//   channel   dir  handshake              payload
//   s_axis    in   tvalid / tready        tdata = data_byte, tlast = end_of_payload
//   m_axis    out  tvalid / tready        tdata = out_byte, tlast = payload_done,
//                                         tuser = {was_masked, run_last}
//   cfg       in   valid / ready(=1)      index, data (64 bit)
//
// Passthrough bytes go in and out at one item per cycle while the output
// is not stalled. A comma in the masked region expands into the mask bytes
// and then the comma, the closing mask at payload end into the mask bytes;
// a two-entry command queue absorbs that and holds off the input once full.
// Reset restores the default configuration and clears the payload state.
// Either side may stall at any time without loss.
// ----------------------------------------------------------------------------
module csv_trailing_field_masker #(
    parameter int unsigned MAX_MASK_BYTES = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ctfm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]                    i_cfg_data,
    // input stream
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [7:0]                     i_s_axis_tdata,  // [7:0] data_byte
    input  logic                           i_s_axis_tlast,
    // output stream
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [7:0]                     o_m_axis_tdata,  // [7:0] out_byte
    output logic                           o_m_axis_tlast,
    output logic [1:0]                     o_m_axis_tuser   // [0] run_last, [1] was_masked
);
    import ctfm_pkg::*;

    t_cfg  r_cfg;
    logic  cfg_we;
    logic  q_ready, q_push, q_valid, q_pop;
    t_cmd  push_cmd, head_cmd;
    logic  run_last, was_masked;

    // configuration registers
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.keep_fields <= RST_KEEP_FIELDS;
            r_cfg.mask_length <= RST_MASK_LENGTH;
            r_cfg.mask_text   <= RST_MASK_TEXT;
        end else if (cfg_we) begin
            unique case (i_cfg_index)
                CFG_IDX_KEEP_FIELDS: r_cfg.keep_fields <= i_cfg_data[3:0];
                CFG_IDX_MASK_LENGTH: r_cfg.mask_length <= i_cfg_data[3:0];
                CFG_IDX_MASK_TEXT:   r_cfg.mask_text   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // front end: classify input items
    ctfm_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_data    (i_s_axis_tdata),
        .i_last    (i_s_axis_tlast),
        .i_q_ready (q_ready),
        .o_push    (q_push),
        .o_cmd     (push_cmd)
    );

    // command queue
    ctfm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    // back end: expand commands into output items
    ctfm_back #(
        .MAX_MASK_BYTES (MAX_MASK_BYTES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_valid  (q_valid),
        .i_q_cmd    (head_cmd),
        .o_q_pop    (q_pop),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_byte     (o_m_axis_tdata),
        .o_run_last (run_last),
        .o_done     (o_m_axis_tlast),
        .o_masked   (was_masked)
    );

    assign o_m_axis_tuser = {was_masked, run_last};

endmodule
